[src/btpc_pkg.sv]
// Shared types, widths and register codes for the barometer compensation block.
// No dependencies; imported by btpc_regs and the top level.
`timescale 1ns / 1ps

package btpc_pkg;

    // Fraction bits of the internal linear temperature, and of the pressure sum.
    localparam int FRAC_BITS  = 16;
    localparam int PRESS_FRAC = 14;

    // Datapath widths; T_W and the widths after it derive from FRAC_BITS.
    localparam int D_W   = 25;                          // raw_temperature - 256*t1
    localparam int X_W   = 60;                          // temperature scaled by 2^48
    localparam int T_W   = X_W - 48 + FRAC_BITS;        // linear temperature
    localparam int TT_W  = 2 * T_W;                     // T*T before floor
    localparam int T2_W  = TT_W - FRAC_BITS;            // T^2
    localparam int L2    = T2_W / 2;                    // split point of T^2
    localparam int T3F_W = T2_W + T_W + 1;              // T^2*T before floor
    localparam int T3_W  = T3F_W - FRAC_BITS;           // T^3
    localparam int L3    = T3_W / 2;                    // split point of T^3

    // APB register map: 64-bit registers at 8-byte spacing.
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_TEMP_TRIM      = 3'd0;
    localparam logic [2:0] REG_PRESS_LIN      = 3'd1;
    localparam logic [2:0] REG_PRESS_SQ_CU    = 3'd2;
    localparam logic [2:0] REG_PRESS_OFFSET   = 3'd3;
    localparam logic [2:0] REG_PRESS_OFFSET_H = 3'd4;
    localparam logic [2:0] REG_PRESS_SQUARE   = 3'd5;
    localparam logic [2:0] REG_PRESS_HIGH     = 3'd6;

    typedef struct packed {
        logic [39:0] temp_trim;
        logic [31:0] press_trim_lin;
        logic [15:0] press_trim_sq_cu;
        logic [31:0] press_trim_offset;
        logic [15:0] press_trim_offset_hi;
        logic [15:0] press_trim_square;
        logic [15:0] press_trim_high;
    } btpc_trim_t;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } btpc_in_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic        [23:0] pressure_centi;
    } btpc_out_t;

endpackage

[src/btpc_regs.sv]
// APB trim register file for the barometer compensation block.
// Depends on btpc_pkg (register codes, trim struct).
`timescale 1ns / 1ps

module btpc_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [btpc_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [btpc_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [btpc_pkg::CFG_DATA_W-1:0]       prdata,
    output btpc_pkg::btpc_trim_t                  trim
);
    import btpc_pkg::*;

    btpc_trim_t trim_reg;
    btpc_trim_t trim_next;
    logic [2:0] index;
    logic       wr_en;

    assign index = paddr[CFG_ADDR_W-1:3];
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        trim_next = trim_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_TEMP_TRIM:      trim_next.temp_trim            = pwdata[39:0];
                REG_PRESS_LIN:      trim_next.press_trim_lin       = pwdata[31:0];
                REG_PRESS_SQ_CU:    trim_next.press_trim_sq_cu     = pwdata[15:0];
                REG_PRESS_OFFSET:   trim_next.press_trim_offset    = pwdata[31:0];
                REG_PRESS_OFFSET_H: trim_next.press_trim_offset_hi = pwdata[15:0];
                REG_PRESS_SQUARE:   trim_next.press_trim_square    = pwdata[15:0];
                REG_PRESS_HIGH:     trim_next.press_trim_high      = pwdata[15:0];
                default:            trim_next = trim_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_TEMP_TRIM:      prdata = 64'(trim_reg.temp_trim);
            REG_PRESS_LIN:      prdata = 64'(trim_reg.press_trim_lin);
            REG_PRESS_SQ_CU:    prdata = 64'(trim_reg.press_trim_sq_cu);
            REG_PRESS_OFFSET:   prdata = 64'(trim_reg.press_trim_offset);
            REG_PRESS_OFFSET_H: prdata = 64'(trim_reg.press_trim_offset_hi);
            REG_PRESS_SQUARE:   prdata = 64'(trim_reg.press_trim_square);
            REG_PRESS_HIGH:     prdata = 64'(trim_reg.press_trim_high);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= '0;
        end
        else
        begin
            trim_reg <= trim_next;
        end
    end

    assign trim = trim_reg;

endmodule

[src/baro_temp_pressure_compensation_top.sv]
// The sample is captured in stage A and passes through stages B to I; done and result
// are registered in stage J, the last stage.
// Throughput: one sample pair per cycle; busy is never high, and the ten-stage
// multiplier pipeline has no stall.
// done and result hold for exactly one cycle; the receiver cannot stall.
// Reset clears the stage valid bits and all trim registers to zero. Depends on btpc_pkg, btpc_regs.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  btpc_pkg::btpc_in_t                sample,
    output logic                              done,
    output btpc_pkg::btpc_out_t               result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [btpc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [btpc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [btpc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import btpc_pkg::*;

    // ------------------------------------------------------------------
    // Local widths and floor shifts of the pressure terms. Each term is
    // floored on its own to the 2^-PRESS_FRAC Pa grid, then summed.
    // ------------------------------------------------------------------
    localparam int P6_W  = T_W + 17;
    localparam int Q2L_W = T_W + 22;
    localparam int Q2H_W = T_W + 21;
    localparam int F2_W  = T_W + 43;
    localparam int Q10L_W = T_W + 30;
    localparam int Q10H_W = T_W + 29;
    localparam int F10_W = T_W + 59;
    localparam int TC_W  = T_W + 8;
    localparam int P7_W  = T2_W + 8;
    localparam int Q3L_W = L2 + 1 + T_W;
    localparam int Q3H_W = T2_W - L2 + T_W;
    localparam int R3L_W = L2 + 1 + 33;
    localparam int R3H_W = T2_W - L2 + 33;
    localparam int R3F_W = T2_W + 34;
    localparam int P8_W  = T3_W + 8;
    localparam int S4L_W = L3 + 1 + 33;
    localparam int S4H_W = T3_W - L3 + 33;
    localparam int S4F_W = T3_W + 34;

    localparam int SH1  = 20 - PRESS_FRAC;
    localparam int SH2  = FRAC_BITS + 29 - PRESS_FRAC;
    localparam int SH3  = FRAC_BITS + 32 - PRESS_FRAC;
    localparam int SH4  = FRAC_BITS + 37 - PRESS_FRAC;
    localparam int SH6  = FRAC_BITS + 6 - PRESS_FRAC;
    localparam int SH7  = FRAC_BITS + 8 - PRESS_FRAC;
    localparam int SH8  = FRAC_BITS + 15 - PRESS_FRAC;
    localparam int SH9  = 48 - PRESS_FRAC;
    localparam int SH10 = FRAC_BITS + 48 - PRESS_FRAC;
    localparam int SH11 = 65 - PRESS_FRAC;

    localparam logic signed [7:0]      CENTI  = 8'sd100;
    localparam logic signed [TC_W-1:0] T_HALF = TC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [63:0]     P_HALF = 64'(1) << (PRESS_FRAC - 1);
    localparam int TEMP_MAX = 32767;
    localparam int TEMP_MIN = -32768;
    localparam logic signed [63:0] PRESS_MAX = 64'sd16777215;

    localparam int STAGES = 10;

    // ------------------------------------------------------------------
    // Trim registers and their decoded fields
    // ------------------------------------------------------------------
    btpc_trim_t trim;

    btpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .trim    (trim)
    );

    assign pready = 1'b1;
    assign busy   = 1'b0;

    logic        [15:0] t1;
    logic signed [16:0] t2_s;
    logic signed [7:0]  t3_s;
    logic signed [16:0] p1_m;
    logic signed [16:0] p2_m;
    logic signed [7:0]  p3_s;
    logic signed [7:0]  p4_s;
    logic        [15:0] p5;
    logic signed [16:0] p6_s;
    logic signed [7:0]  p7_s;
    logic signed [7:0]  p8_s;
    logic signed [15:0] p9_s;
    logic signed [7:0]  p10_s;
    logic signed [7:0]  p11_s;

    assign t1    = trim.temp_trim[15:0];
    assign t2_s  = signed'({1'b0, trim.temp_trim[31:16]});
    assign t3_s  = signed'(trim.temp_trim[39:32]);
    assign p1_m  = 17'(signed'(trim.press_trim_lin[15:0])) - 17'sd16384;
    assign p2_m  = 17'(signed'(trim.press_trim_lin[31:16])) - 17'sd16384;
    assign p3_s  = signed'(trim.press_trim_sq_cu[7:0]);
    assign p4_s  = signed'(trim.press_trim_sq_cu[15:8]);
    assign p5    = trim.press_trim_offset[15:0];
    assign p6_s  = signed'({1'b0, trim.press_trim_offset[31:16]});
    assign p7_s  = signed'(trim.press_trim_offset_hi[7:0]);
    assign p8_s  = signed'(trim.press_trim_offset_hi[15:8]);
    assign p9_s  = signed'(trim.press_trim_square);
    assign p10_s = signed'(trim.press_trim_high[7:0]);
    assign p11_s = signed'(trim.press_trim_high[15:8]);

    // ------------------------------------------------------------------
    // Valid bits, one per stage; bit 0 is stage A, the last is stage J.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    assign valid_next = {valid_reg[STAGES-2:0], start & ~busy};

    // Stage A: sample capture, d = raw_temperature - 256*t1
    logic        [23:0]      a_p_reg, a_p_next;
    logic signed [D_W-1:0]   a_d_reg, a_d_next;

    // Stage B: first-level products of d and P
    logic signed [41:0]      b_dt2_reg, b_dt2_next;
    logic signed [32:0]      b_dt3_reg, b_dt3_next;
    logic signed [D_W-1:0]   b_d_reg, b_d_next;
    logic signed [41:0]      b_pp1_reg, b_pp1_next;
    logic signed [41:0]      b_pp2_reg, b_pp2_next;
    logic signed [32:0]      b_pp3_reg, b_pp3_next;
    logic signed [32:0]      b_pp4_reg, b_pp4_next;
    logic signed [32:0]      b_pp11_reg, b_pp11_next;
    logic signed [49:0]      b_p2_reg, b_p2_next;

    // Stage C: linear temperature T, P^2 products
    logic signed [T_W-1:0]   c_t_reg, c_t_next;
    logic signed [65:0]      c_p2p9_reg, c_p2p9_next;
    logic signed [57:0]      c_p2p10_reg, c_p2p10_next;
    logic signed [57:0]      c_q11lo_reg, c_q11lo_next;
    logic signed [58:0]      c_q11hi_reg, c_q11hi_next;
    logic signed [63:0]      c_acc_reg, c_acc_next;
    logic signed [41:0]      c_pp2_reg, c_pp2_next;
    logic signed [32:0]      c_pp3_reg, c_pp3_next;
    logic signed [32:0]      c_pp4_reg, c_pp4_next;

    // Stage D: T*T, partials of T terms, temperature output
    logic signed [TT_W-1:0]  d_tt_reg, d_tt_next;
    logic signed [Q2L_W-1:0] d_q2lo_reg, d_q2lo_next;
    logic signed [Q2H_W-1:0] d_q2hi_reg, d_q2hi_next;
    logic signed [Q10L_W-1:0] d_q10lo_reg, d_q10lo_next;
    logic signed [Q10H_W-1:0] d_q10hi_reg, d_q10hi_next;
    logic signed [63:0]      d_acc_reg, d_acc_next;
    logic signed [15:0]      d_tc_reg, d_tc_next;
    logic signed [T_W-1:0]   d_t_reg, d_t_next;
    logic signed [32:0]      d_pp3_reg, d_pp3_next;
    logic signed [32:0]      d_pp4_reg, d_pp4_next;

    // Stage E: T^2
    logic signed [T2_W-1:0]  e_t2_reg, e_t2_next;
    logic signed [63:0]      e_acc_reg, e_acc_next;
    logic signed [15:0]      e_tc_reg, e_tc_next;
    logic signed [T_W-1:0]   e_t_reg, e_t_next;
    logic signed [32:0]      e_pp3_reg, e_pp3_next;
    logic signed [32:0]      e_pp4_reg, e_pp4_next;

    // Stage F: partials of T^2*T and P*p3*T^2
    logic signed [Q3L_W-1:0] f_q3lo_reg, f_q3lo_next;
    logic signed [Q3H_W-1:0] f_q3hi_reg, f_q3hi_next;
    logic signed [R3L_W-1:0] f_r3lo_reg, f_r3lo_next;
    logic signed [R3H_W-1:0] f_r3hi_reg, f_r3hi_next;
    logic signed [63:0]      f_acc_reg, f_acc_next;
    logic signed [15:0]      f_tc_reg, f_tc_next;
    logic signed [32:0]      f_pp4_reg, f_pp4_next;

    // Stage G: T^3
    logic signed [T3_W-1:0]  g_t3_reg, g_t3_next;
    logic signed [63:0]      g_acc_reg, g_acc_next;
    logic signed [15:0]      g_tc_reg, g_tc_next;
    logic signed [32:0]      g_pp4_reg, g_pp4_next;

    // Stage H: partials of P*p4*T^3
    logic signed [S4L_W-1:0] h_s4lo_reg, h_s4lo_next;
    logic signed [S4H_W-1:0] h_s4hi_reg, h_s4hi_next;
    logic signed [63:0]      h_acc_reg, h_acc_next;
    logic signed [15:0]      h_tc_reg, h_tc_next;

    // Stage I: final pressure sum
    logic signed [63:0]      i_sum_reg, i_sum_next;
    logic signed [15:0]      i_tc_reg, i_tc_next;

    // Stage J: rounded and saturated result
    btpc_out_t               result_reg, result_next;

    // ------------------------------------------------------------------
    // Stage A
    // ------------------------------------------------------------------
    always_comb
    begin
        a_p_next = sample.raw_pressure;
        a_d_next = signed'({1'b0, sample.raw_temperature}) - signed'({1'b0, t1, 8'h00});
    end

    // ------------------------------------------------------------------
    // Stage B
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] p_s;

    always_comb
    begin
        p_s         = signed'({1'b0, a_p_reg});
        b_dt2_next  = 42'(a_d_reg) * 42'(t2_s);
        b_dt3_next  = 33'(a_d_reg) * 33'(t3_s);
        b_d_next    = a_d_reg;
        b_pp1_next  = 42'(p_s) * 42'(p1_m);
        b_pp2_next  = 42'(p_s) * 42'(p2_m);
        b_pp3_next  = 33'(p_s) * 33'(p3_s);
        b_pp4_next  = 33'(p_s) * 33'(p4_s);
        b_pp11_next = 33'(p_s) * 33'(p11_s);
        b_p2_next   = 50'(p_s) * 50'(p_s);
    end

    // ------------------------------------------------------------------
    // Stage C: X = d*t2*2^18 + d*(d*t3); T is X floored to FRAC_BITS
    // ------------------------------------------------------------------
    logic signed [X_W-1:0] x_val;
    logic signed [24:0]    p2_lo;
    logic signed [25:0]    p2_hi;
    logic signed [63:0]    term1;
    logic signed [63:0]    term5;

    always_comb
    begin
        x_val        = (X_W'(b_dt2_reg) <<< 18) + X_W'(b_d_reg) * X_W'(b_dt3_reg);
        c_t_next     = x_val[X_W-1:48-FRAC_BITS];
        c_p2p9_next  = 66'(b_p2_reg) * 66'(p9_s);
        c_p2p10_next = 58'(b_p2_reg) * 58'(p10_s);
        p2_lo        = signed'({1'b0, b_p2_reg[23:0]});
        p2_hi        = b_p2_reg[49:24];
        c_q11lo_next = 58'(p2_lo) * 58'(b_pp11_reg);
        c_q11hi_next = 59'(p2_hi) * 59'(b_pp11_reg);
        term1        = 64'(b_pp1_reg >>> SH1);
        term5        = signed'(64'(p5) << (PRESS_FRAC + 3));
        c_acc_next   = term5 + term1;
        c_pp2_next   = b_pp2_reg;
        c_pp3_next   = b_pp3_reg;
        c_pp4_next   = b_pp4_reg;
    end

    // ------------------------------------------------------------------
    // Stage D
    // ------------------------------------------------------------------
    logic signed [P6_W-1:0] prod6;
    logic signed [21:0]     pp2_lo;
    logic signed [20:0]     pp2_hi;
    logic signed [29:0]     p2p10_lo;
    logic signed [28:0]     p2p10_hi;
    logic signed [83:0]     full11;
    logic signed [63:0]     term6;
    logic signed [63:0]     term9;
    logic signed [63:0]     term11;
    logic signed [TC_W-1:0] t100;
    logic signed [TC_W-1:0] tc_full;

    always_comb
    begin
        d_tt_next    = TT_W'(c_t_reg) * TT_W'(c_t_reg);
        prod6        = P6_W'(p6_s) * P6_W'(c_t_reg);
        term6        = 64'(prod6 >>> SH6);
        pp2_lo       = signed'({1'b0, c_pp2_reg[20:0]});
        pp2_hi       = c_pp2_reg[41:21];
        d_q2lo_next  = Q2L_W'(pp2_lo) * Q2L_W'(c_t_reg);
        d_q2hi_next  = Q2H_W'(pp2_hi) * Q2H_W'(c_t_reg);
        p2p10_lo     = signed'({1'b0, c_p2p10_reg[28:0]});
        p2p10_hi     = c_p2p10_reg[57:29];
        d_q10lo_next = Q10L_W'(p2p10_lo) * Q10L_W'(c_t_reg);
        d_q10hi_next = Q10H_W'(p2p10_hi) * Q10H_W'(c_t_reg);
        full11       = (84'(c_q11hi_reg) <<< 24) + 84'(c_q11lo_reg);
        term11       = 64'(full11 >>> SH11);
        term9        = 64'(c_p2p9_reg >>> SH9);
        d_acc_next   = c_acc_reg + term6 + term9 + term11;

        // temperature: round half up to 1/100 degC, then clamp
        t100    = TC_W'(c_t_reg) * TC_W'(CENTI);
        tc_full = (t100 + T_HALF) >>> FRAC_BITS;
        if (tc_full > TEMP_MAX)
        begin
            d_tc_next = 16'sh7FFF;
        end
        else if (tc_full < TEMP_MIN)
        begin
            d_tc_next = -16'sh8000;
        end
        else
        begin
            d_tc_next = 16'(tc_full);
        end

        d_t_next   = c_t_reg;
        d_pp3_next = c_pp3_reg;
        d_pp4_next = c_pp4_reg;
    end

    // ------------------------------------------------------------------
    // Stage E
    // ------------------------------------------------------------------
    logic signed [F2_W-1:0]  full2;
    logic signed [F10_W-1:0] full10;
    logic signed [63:0]      term2;
    logic signed [63:0]      term10;

    always_comb
    begin
        e_t2_next  = d_tt_reg[TT_W-1:FRAC_BITS];
        full2      = (F2_W'(d_q2hi_reg) <<< 21) + F2_W'(d_q2lo_reg);
        term2      = 64'(full2 >>> SH2);
        full10     = (F10_W'(d_q10hi_reg) <<< 29) + F10_W'(d_q10lo_reg);
        term10     = 64'(full10 >>> SH10);
        e_acc_next = d_acc_reg + term2 + term10;
        e_tc_next  = d_tc_reg;
        e_t_next   = d_t_reg;
        e_pp3_next = d_pp3_reg;
        e_pp4_next = d_pp4_reg;
    end

    // ------------------------------------------------------------------
    // Stage F: T^2 split into halves for the two wide products
    // ------------------------------------------------------------------
    logic signed [L2:0]        t2_lo;
    logic signed [T2_W-L2-1:0] t2_hi;
    logic signed [P7_W-1:0]    prod7;
    logic signed [63:0]        term7;

    always_comb
    begin
        t2_lo       = signed'({1'b0, e_t2_reg[L2-1:0]});
        t2_hi       = e_t2_reg[T2_W-1:L2];
        f_q3lo_next = Q3L_W'(t2_lo) * Q3L_W'(e_t_reg);
        f_q3hi_next = Q3H_W'(t2_hi) * Q3H_W'(e_t_reg);
        f_r3lo_next = R3L_W'(t2_lo) * R3L_W'(e_pp3_reg);
        f_r3hi_next = R3H_W'(t2_hi) * R3H_W'(e_pp3_reg);
        prod7       = P7_W'(p7_s) * P7_W'(e_t2_reg);
        term7       = 64'(prod7 >>> SH7);
        f_acc_next  = e_acc_reg + term7;
        f_tc_next   = e_tc_reg;
        f_pp4_next  = e_pp4_reg;
    end

    // ------------------------------------------------------------------
    // Stage G
    // ------------------------------------------------------------------
    logic signed [T3F_W-1:0] full3;
    logic signed [R3F_W-1:0] fullr3;
    logic signed [63:0]      term3;

    always_comb
    begin
        full3      = (T3F_W'(f_q3hi_reg) <<< L2) + T3F_W'(f_q3lo_reg);
        g_t3_next  = full3[T3F_W-1:FRAC_BITS];
        fullr3     = (R3F_W'(f_r3hi_reg) <<< L2) + R3F_W'(f_r3lo_reg);
        term3      = 64'(fullr3 >>> SH3);
        g_acc_next = f_acc_reg + term3;
        g_tc_next  = f_tc_reg;
        g_pp4_next = f_pp4_reg;
    end

    // ------------------------------------------------------------------
    // Stage H
    // ------------------------------------------------------------------
    logic signed [L3:0]        t3_lo;
    logic signed [T3_W-L3-1:0] t3_hi;
    logic signed [P8_W-1:0]    prod8;
    logic signed [63:0]        term8;

    always_comb
    begin
        t3_lo       = signed'({1'b0, g_t3_reg[L3-1:0]});
        t3_hi       = g_t3_reg[T3_W-1:L3];
        h_s4lo_next = S4L_W'(t3_lo) * S4L_W'(g_pp4_reg);
        h_s4hi_next = S4H_W'(t3_hi) * S4H_W'(g_pp4_reg);
        prod8       = P8_W'(p8_s) * P8_W'(g_t3_reg);
        term8       = 64'(prod8 >>> SH8);
        h_acc_next  = g_acc_reg + term8;
        h_tc_next   = g_tc_reg;
    end

    // ------------------------------------------------------------------
    // Stage I
    // ------------------------------------------------------------------
    logic signed [S4F_W-1:0] full4;
    logic signed [63:0]      term4;

    always_comb
    begin
        full4      = (S4F_W'(h_s4hi_reg) <<< L3) + S4F_W'(h_s4lo_reg);
        term4      = 64'(full4 >>> SH4);
        i_sum_next = h_acc_reg + term4;
        i_tc_next  = h_tc_reg;
    end

    // ------------------------------------------------------------------
    // Stage J: sum*100 by shift-add, round half up to 1/100 Pa, clamp
    // ------------------------------------------------------------------
    logic signed [63:0] s100;
    logic signed [63:0] pc_full;

    always_comb
    begin
        s100    = (i_sum_reg <<< 6) + (i_sum_reg <<< 5) + (i_sum_reg <<< 2) + P_HALF;
        pc_full = s100 >>> PRESS_FRAC;
        result_next.temperature_centi = i_tc_reg;
        if (pc_full < 0)
        begin
            result_next.pressure_centi = 24'h000000;
        end
        else if (pc_full > PRESS_MAX)
        begin
            result_next.pressure_centi = 24'hFFFFFF;
        end
        else
        begin
            result_next.pressure_centi = pc_full[23:0];
        end
    end

    // ------------------------------------------------------------------
    // Registers: valid bits reset, payload loads every cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p_reg     <= a_p_next;
        a_d_reg     <= a_d_next;

        b_dt2_reg   <= b_dt2_next;
        b_dt3_reg   <= b_dt3_next;
        b_d_reg     <= b_d_next;
        b_pp1_reg   <= b_pp1_next;
        b_pp2_reg   <= b_pp2_next;
        b_pp3_reg   <= b_pp3_next;
        b_pp4_reg   <= b_pp4_next;
        b_pp11_reg  <= b_pp11_next;
        b_p2_reg    <= b_p2_next;

        c_t_reg     <= c_t_next;
        c_p2p9_reg  <= c_p2p9_next;
        c_p2p10_reg <= c_p2p10_next;
        c_q11lo_reg <= c_q11lo_next;
        c_q11hi_reg <= c_q11hi_next;
        c_acc_reg   <= c_acc_next;
        c_pp2_reg   <= c_pp2_next;
        c_pp3_reg   <= c_pp3_next;
        c_pp4_reg   <= c_pp4_next;

        d_tt_reg    <= d_tt_next;
        d_q2lo_reg  <= d_q2lo_next;
        d_q2hi_reg  <= d_q2hi_next;
        d_q10lo_reg <= d_q10lo_next;
        d_q10hi_reg <= d_q10hi_next;
        d_acc_reg   <= d_acc_next;
        d_tc_reg    <= d_tc_next;
        d_t_reg     <= d_t_next;
        d_pp3_reg   <= d_pp3_next;
        d_pp4_reg   <= d_pp4_next;

        e_t2_reg    <= e_t2_next;
        e_acc_reg   <= e_acc_next;
        e_tc_reg    <= e_tc_next;
        e_t_reg     <= e_t_next;
        e_pp3_reg   <= e_pp3_next;
        e_pp4_reg   <= e_pp4_next;

        f_q3lo_reg  <= f_q3lo_next;
        f_q3hi_reg  <= f_q3hi_next;
        f_r3lo_reg  <= f_r3lo_next;
        f_r3hi_reg  <= f_r3hi_next;
        f_acc_reg   <= f_acc_next;
        f_tc_reg    <= f_tc_next;
        f_pp4_reg   <= f_pp4_next;

        g_t3_reg    <= g_t3_next;
        g_acc_reg   <= g_acc_next;
        g_tc_reg    <= g_tc_next;
        g_pp4_reg   <= g_pp4_next;

        h_s4lo_reg  <= h_s4lo_next;
        h_s4hi_reg  <= h_s4hi_next;
        h_acc_reg   <= h_acc_next;
        h_tc_reg    <= h_tc_next;

        i_sum_reg   <= i_sum_next;
        i_tc_reg    <= i_tc_next;

        result_reg  <= result_next;
    end

    assign done   = valid_reg[STAGES-1];
    assign result = result_reg;

endmodule

[dv/baro_temp_pressure_compensation_top_tb.sv]
// Testbench for baro_temp_pressure_compensation_top: directed table, then random
// sample pairs over several trim settings, checked against an exact-integer predictor.
// Depends on btpc_pkg and the top level RTL.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_top_tb;

    import btpc_pkg::*;

    typedef logic signed [127:0] wide_t;

    // Directed stimulus row; exp_known marks rows whose result is typed in.
    typedef struct {
        logic [23:0]        pressure;
        logic [23:0]        temperature;
        bit                 exp_known;
        logic signed [15:0] exp_temp;
        logic [23:0]        exp_press;
    } vec_t;

    localparam int LATENCY  = 10;
    localparam int WDOG_MAX = 5000;
    localparam int N_PHASE  = 7;
    localparam int PER_PHASE = 250;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    btpc_in_t                sample;
    logic                    done;
    btpc_out_t               result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // Shadow of the trim registers as the block should hold them.
    btpc_trim_t  trim_shadow;
    btpc_out_t   pending_results[$];
    int          errors;
    int          idle_cycles;
    int          gap_mode;

    baro_temp_pressure_compensation_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .sample  (sample),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: exact integer compensation. Arithmetic shift right of a
    // signed value is floor division by a power of two, which is what every
    // truncation step calls for.
    // ------------------------------------------------------------------
    function automatic btpc_out_t compensate(btpc_in_t s);
        wide_t     pr, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        wide_t     d, x, tl, tsq, tcu, tc, psq, acc, pc;
        btpc_out_t r;
        pr  = s.raw_pressure;
        rt  = s.raw_temperature;
        t1  = trim_shadow.temp_trim[15:0];
        t2  = trim_shadow.temp_trim[31:16];
        t3  = $signed(trim_shadow.temp_trim[39:32]);
        p1  = $signed(trim_shadow.press_trim_lin[15:0]);
        p2  = $signed(trim_shadow.press_trim_lin[31:16]);
        p3  = $signed(trim_shadow.press_trim_sq_cu[7:0]);
        p4  = $signed(trim_shadow.press_trim_sq_cu[15:8]);
        p5  = trim_shadow.press_trim_offset[15:0];
        p6  = trim_shadow.press_trim_offset[31:16];
        p7  = $signed(trim_shadow.press_trim_offset_hi[7:0]);
        p8  = $signed(trim_shadow.press_trim_offset_hi[15:8]);
        p9  = $signed(trim_shadow.press_trim_square);
        p10 = $signed(trim_shadow.press_trim_high[7:0]);
        p11 = $signed(trim_shadow.press_trim_high[15:8]);

        // linear temperature, then its square and cube, all at FRAC_BITS
        d   = rt - t1 * 256;
        x   = d * t2 * 262144 + d * d * t3;
        tl  = x >>> (48 - FRAC_BITS);
        tsq = (tl * tl) >>> FRAC_BITS;
        tcu = (tsq * tl) >>> FRAC_BITS;

        tc = (tl * 100 + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (tc > 32767)
            tc = 32767;
        if (tc < -32768)
            tc = -32768;

        // each pressure term floored on its own to the 2^-14 grid
        psq = pr * pr;
        acc = p5 * (wide_t'(1) <<< (PRESS_FRAC + 3));
        acc += (p6 * tl) >>> (FRAC_BITS + 6 - PRESS_FRAC);
        acc += (p7 * tsq) >>> (FRAC_BITS + 8 - PRESS_FRAC);
        acc += (p8 * tcu) >>> (FRAC_BITS + 15 - PRESS_FRAC);
        acc += (pr * (p1 - 16384)) >>> (20 - PRESS_FRAC);
        acc += (pr * (p2 - 16384) * tl) >>> (FRAC_BITS + 29 - PRESS_FRAC);
        acc += (pr * p3 * tsq) >>> (FRAC_BITS + 32 - PRESS_FRAC);
        acc += (pr * p4 * tcu) >>> (FRAC_BITS + 37 - PRESS_FRAC);
        acc += (psq * p9) >>> (48 - PRESS_FRAC);
        acc += (psq * p10 * tl) >>> (FRAC_BITS + 48 - PRESS_FRAC);
        acc += (psq * pr * p11) >>> (65 - PRESS_FRAC);

        pc = (acc * 100 + (wide_t'(1) <<< (PRESS_FRAC - 1))) >>> PRESS_FRAC;
        if (pc < 0)
            pc = 0;
        if (pc > 24'hFFFFFF)
            pc = 24'hFFFFFF;

        r.temperature_centi = tc[15:0];
        r.pressure_centi    = pc[23:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker. done is a one-cycle strobe; every strobe must match
    // the oldest pending prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        btpc_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: temperature_centi %0d pressure_centi %0d",
                       result.temperature_centi, result.pressure_centi);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                begin
                    $error("temperature_centi: expected %0d, got %0d",
                           want.temperature_centi, result.temperature_centi);
                    errors++;
                end
                if (result.pressure_centi !== want.pressure_centi)
                begin
                    $error("pressure_centi: expected %0d, got %0d",
                           want.pressure_centi, result.pressure_centi);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no sample transfer, no result and no
    // register write. The longest honest stall is a long gap plus a drain.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("baro_temp_pressure_compensation_top_tb: FAIL");
            $finish;
        end
    end

    // APB write: setup, access, then back to idle; the shadow follows
    // the width masks.
    task automatic trim_write(input int idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP_TRIM:      trim_shadow.temp_trim            = value[39:0];
            REG_PRESS_LIN:      trim_shadow.press_trim_lin       = value[31:0];
            REG_PRESS_SQ_CU:    trim_shadow.press_trim_sq_cu     = value[15:0];
            REG_PRESS_OFFSET:   trim_shadow.press_trim_offset    = value[31:0];
            REG_PRESS_OFFSET_H: trim_shadow.press_trim_offset_hi = value[15:0];
            REG_PRESS_SQUARE:   trim_shadow.press_trim_square    = value[15:0];
            REG_PRESS_HIGH:     trim_shadow.press_trim_high      = value[15:0];
            default: ;  // out-of-map write, block ignores it
        endcase
        @(posedge clk);
    endtask

    // Trims may only change with nothing in flight.
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // One sample transfer. start stays high across back-to-back items.
    task automatic send_sample(input logic [23:0] pressure, input logic [23:0] temperature,
                               input bit exp_known, input btpc_out_t exp_val);
        btpc_in_t  s;
        btpc_out_t pred;
        int        gap;
        s.raw_pressure    = pressure;
        s.raw_temperature = temperature;
        start  <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = compensate(s);
        if (exp_known && pred !== exp_val)
        begin
            $error("predictor disagrees with table: expected %0d/%0d, predicted %0d/%0d",
                   exp_val.temperature_centi, exp_val.pressure_centi,
                   pred.temperature_centi, pred.pressure_centi);
            errors++;
        end
        pending_results.push_back(exp_known ? exp_val : pred);
        // gap_mode 0 gives a stretch with no idling at all
        gap = 0;
        if (gap_mode != 0)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: gap = 0;
                5, 6, 7, 8:    gap = $urandom_range(1, 3);
                default:       gap = $urandom_range(10, 60);
            endcase
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Trim sets: tame values keep pressure mostly in range; the others
    // drive the signed/unsigned extremes and plain random words.
    task automatic load_trims(input int phase);
        logic [63:0] v [7];
        case (phase)
            0:
            begin
                // everything all ones
                foreach (v[i])
                    v[i] = '1;
            end
            1:
            begin
                // signed fields at their most negative, unsigned at zero
                v[0] = 64'h80_0000_0000;
                v[1] = 64'h8000_8000;
                v[2] = 64'h8080;
                v[3] = 64'h0;
                v[4] = 64'h8080;
                v[5] = 64'h8000;
                v[6] = 64'h8080;
            end
            2, 5:
            begin
                foreach (v[i])
                    v[i] = {$urandom(), $urandom()};
            end
            default:
            begin
                v[0] = {24'h0, 8'($urandom_range(0, 15) - 8), 16'($urandom_range(20000, 30000)),
                        16'($urandom_range(20000, 30000))};
                v[1] = {32'h0, 16'($urandom_range(16000, 17000)),
                        16'($urandom_range(16200, 16600))};
                v[2] = {48'h0, 8'($urandom_range(0, 7) - 4), 8'($urandom_range(0, 7) - 4)};
                v[3] = {32'h0, 16'($urandom_range(0, 40000)), 16'($urandom_range(10000, 30000))};
                v[4] = {48'h0, 8'($urandom_range(0, 7) - 4), 8'($urandom_range(0, 7) - 4)};
                v[5] = {48'h0, 16'($urandom_range(0, 255) - 128)};
                v[6] = {48'h0, 8'($urandom_range(0, 7) - 4), 8'($urandom_range(0, 7) - 4)};
            end
        endcase
        for (int i = 0; i < 7; i++)
            trim_write(i, v[i]);
        trim_write(7, {$urandom(), $urandom()});  // beyond the map: ignored
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        vec_t        table_rows[$];
        btpc_out_t   ev;
        logic [23:0] rp, rt;
        logic [23:0] base;

        errors      = 0;
        idle_cycles = 0;
        gap_mode    = 1;
        start       = 1'b0;
        sample      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        trim_shadow = '0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With every trim zero after reset the temperature is
        // zero and the pressure sum is -256*P, so any P saturates to 0.
        table_rows.push_back('{24'h000000, 24'h000000, 1, 16'sd0, 24'd0});
        table_rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 1, 16'sd0, 24'd0});
        table_rows.push_back('{24'hFFFFFF, 24'h000000, 1, 16'sd0, 24'd0});
        table_rows.push_back('{24'h000000, 24'hFFFFFF, 1, 16'sd0, 24'd0});
        table_rows.push_back('{24'h800000, 24'h800000, 1, 16'sd0, 24'd0});
        table_rows.push_back('{24'h000001, 24'h7FFFFF, 1, 16'sd0, 24'd0});
        foreach (table_rows[i])
        begin
            ev.temperature_centi = table_rows[i].exp_temp;
            ev.pressure_centi    = table_rows[i].exp_press;
            send_sample(table_rows[i].pressure, table_rows[i].temperature,
                        table_rows[i].exp_known, ev);
        end
        start <= 1'b0;
        drain();

        // Predicted rows: extremes under the extreme trim sets, covering the
        // saturation cases and half-up rounding at both ends.
        load_trims(0);
        table_rows.delete();
        table_rows.push_back('{24'h000000, 24'h000000, 0, 16'sd0, 24'd0});
        table_rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 0, 16'sd0, 24'd0});
        table_rows.push_back('{24'hFFFFFF, 24'hFFFF00, 0, 16'sd0, 24'd0});
        table_rows.push_back('{24'h000001, 24'hFFFF01, 0, 16'sd0, 24'd0});
        foreach (table_rows[i])
            send_sample(table_rows[i].pressure, table_rows[i].temperature, 0, ev);
        start <= 1'b0;
        drain();
        load_trims(1);
        foreach (table_rows[i])
            send_sample(table_rows[i].pressure, table_rows[i].temperature, 0, ev);
        start <= 1'b0;
        drain();

        // Random part, one trim set per phase.
        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            load_trims(ph);
            gap_mode = (ph == 3) ? 0 : 1;
            base = {trim_shadow.temp_trim[15:0], 8'h00};
            for (int n = 0; n < PER_PHASE; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: rt = base + 24'($urandom_range(0, 8192)) - 24'd4096;
                    5:             rt = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                    default:       rt = 24'($urandom_range(24'hFFFFFF));
                endcase
                case ($urandom_range(9))
                    0:       rp = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                    1, 2, 3: rp = 24'($urandom_range(24'h500000, 24'h700000));
                    default: rp = 24'($urandom_range(24'hFFFFFF));
                endcase
                send_sample(rp, rt, 0, ev);
            end
            start <= 1'b0;
            drain();
        end

        // Nothing left in flight; a last settle for any stray strobe.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 2) @(posedge clk);
        if (errors == 0)
            $display("baro_temp_pressure_compensation_top_tb: PASS");
        else
            $display("baro_temp_pressure_compensation_top_tb: FAIL");
        $finish;
    end

endmodule

[baro_temp_pressure_compensation_top.f]
src/btpc_pkg.sv
src/btpc_regs.sv
src/baro_temp_pressure_compensation_top.sv
dv/baro_temp_pressure_compensation_top_tb.sv
